>>> src/jgr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Jacobi grid relaxation block.
// No dependencies; imported by every other file in src.
package jgr_pkg;

	localparam int MODE_W = 2;
	localparam int IDX_W  = 5;
	localparam int CIDX_W = 2;
	localparam int CFG_W  = 23;
	localparam int GS_W   = 6;
	localparam int TOL_W  = 23;
	localparam int MS_W   = 16;
	localparam int SC_W   = 16;

	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [CIDX_W-1:0] REG_GRID_SIZE  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_TOLERANCE  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MAX_SWEEPS = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic host_wr;   // cell write transfer
		logic host_rd;   // cell read transfer
		logic start;     // run transfer: load limits, clear counters
		logic rd_vert;   // issue reads of upper and lower neighbours
		logic rd_horz;   // issue reads of left and right neighbours
		logic rd_mid;    // issue read of the centre cell
		logic add_vert;  // accumulate vertical pair
		logic add_horz;  // accumulate horizontal pair
		logic upd;       // write new value, form change
		logic cpy;       // copy centre cell into the spare bank
		logic step;      // advance to next interior cell
		logic sweep_end; // count sweep, swap banks, latch convergence
	} jgr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_cell;
		logic stop;
	} jgr_stat_t;

	// controller -> result queue / result mux
	typedef struct packed {
		logic host; // result of a write, read or unused mode
		logic rd;   // that result carries read data
		logic run;  // result of a run
	} jgr_push_t;

endpackage

>>> src/jacobi_grid_relaxation.sv
`timescale 1ns / 1ps
// Jacobi relaxation, 4-point stencil, on a square grid of signed fixed-point cells.
// A write or read result is queued after its transfer; writes and reads are
//   taken one per cycle while no run is busy and the result queue has room. A run's
//   result follows its sweeps and a copy pass over the (n-2)^2 interior cells of clamped side n.
// Reset: asynchronous, active low; clears control and config (size 20, tolerance
//   655, sweep limit 65535). Grid banks are not cleared.
module jacobi_grid_relaxation #(
	parameter int GRID_MAX   = 32,
	parameter int VALUE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [jgr_pkg::MODE_W-1:0]    mode,
	input  logic [jgr_pkg::IDX_W-1:0]     row,
	input  logic [jgr_pkg::IDX_W-1:0]     col,
	input  logic signed [VALUE_BITS-1:0]  value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_BITS-1:0]  read_value,
	output logic [jgr_pkg::SC_W-1:0]      sweep_count,
	output logic                          converged,
	// config write port
	input  logic                          cfg_we,
	input  logic [jgr_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [jgr_pkg::CFG_W-1:0]     cfg_data
);
	import jgr_pkg::*;

	jgr_cmd_t  cmd;
	jgr_stat_t stat;
	jgr_push_t push;

	logic [1:0]                   q_cnt;
	logic                         q_pop;
	logic signed [VALUE_BITS-1:0] host_value;
	logic [SC_W-1:0]              sweep_total;
	logic                         run_converged;

	logic signed [VALUE_BITS-1:0] push_rv;
	logic [SC_W-1:0]              push_sc;
	logic                         push_cv;

	// Sequencer. Per interior cell: neighbour reads in two pairs, centre read,
	// then write of the new value to the idle bank. After the last cell a flush
	// state folds the final change into the running maximum, then a check state
	// ends the sweep. When the run stops, a copy pass, a read and a write per
	// interior cell, writes the fresh interior into the spare bank.
	jgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_stall (in_stall),
		.q_cnt    (q_cnt),
		.q_pop    (q_pop),
		.stat     (stat),
		.cmd      (cmd),
		.push     (push)
	);

	// Two banks ping-pong between sweeps: one is read, the other takes the new
	// interior. Both hold the same grid between runs: host writes go to both,
	// and the copy pass levels the interior, so a later run with a smaller side
	// still sees the latest values outside its interior.
	jgr_dp #(
		.GRID_MAX   (GRID_MAX),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.row           (row),
		.col           (col),
		.value         (value),
		.host_value    (host_value),
		.sweep_total   (sweep_total),
		.run_converged (run_converged)
	);

	// Result fields: read data only for a read, sweep figures only for a run.
	assign push_rv = push.rd  ? host_value  : '0;
	assign push_sc = push.run ? sweep_total : '0;
	assign push_cv = push.run && run_converged;

	// Output queue lets new commands transfer while results wait downstream.
	jgr_outq #(
		.VALUE_BITS (VALUE_BITS)
	) u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push.host || push.run),
		.push_rv     (push_rv),
		.push_sc     (push_sc),
		.push_cv     (push_cv),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.sweep_count (sweep_count),
		.converged   (converged),
		.cnt         (q_cnt),
		.pop         (q_pop)
	);

endmodule

>>> src/jgr_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, two ping-pong grid banks, stencil arithmetic,
// cell walk counters and sweep statistics. Depends on jgr_pkg.
module jgr_dp #(
	parameter int GRID_MAX   = 32,
	parameter int VALUE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  jgr_pkg::jgr_cmd_t                 cmd,
	output jgr_pkg::jgr_stat_t                stat,
	input  logic                              cfg_we,
	input  logic [jgr_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [jgr_pkg::CFG_W-1:0]         cfg_data,
	input  logic [jgr_pkg::IDX_W-1:0]         row,
	input  logic [jgr_pkg::IDX_W-1:0]         col,
	input  logic signed [VALUE_BITS-1:0]      value,
	output logic signed [VALUE_BITS-1:0]      host_value,
	output logic [jgr_pkg::SC_W-1:0]          sweep_total,
	output logic                              run_converged
);
	import jgr_pkg::*;

	localparam int DW    = VALUE_BITS;
	localparam int PW    = DW + 1;
	localparam int SW    = DW + 2;
	localparam int CELLS = GRID_MAX * GRID_MAX;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(GRID_MAX);
	localparam logic [AW-1:0] G_A    = AW'(GRID_MAX);
	localparam logic [AW-1:0] ORIGIN = AW'(GRID_MAX + 1);

	logic [GS_W-1:0]  gs_q;
	logic [TOL_W-1:0] tol_q;
	logic [MS_W-1:0]  msw_q;

	logic signed [DW-1:0] mem0 [CELLS];
	logic signed [DW-1:0] mem1 [CELLS];
	logic signed [DW-1:0] ra0_q, rb0_q, ra1_q, rb1_q;
	logic signed [DW-1:0] da, db;

	logic            cur_q;
	logic            rd_ok_q;
	logic [RW-1:0]   lim_q, i_q, j_q;
	logic [AW-1:0]   ca_q;
	logic [SC_W-1:0] cnt_q;
	logic [DW-1:0]   max_q, diff_q;
	logic            dv_q;
	logic            conv_q;

	logic signed [PW-1:0] psum_q;
	logic signed [SW-1:0] sum_q;
	logic signed [DW-1:0] new_val;
	logic signed [PW-1:0] dsub, dabs;

	logic            h_ok;
	logic [AW-1:0]   h_addr, addr_a, addr_b, waddr;
	logic signed [DW-1:0] wdata;
	logic            we0, we1;
	logic [RW-1:0]   lim_c;
	logic            conv_c, hit_c;
	logic [MS_W-1:0] lim_sw;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q  <= GS_W'(20);
			tol_q <= TOL_W'(655);
			msw_q <= MS_W'(65535);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_SIZE:  gs_q  <= cfg_data[GS_W-1:0];
				REG_TOLERANCE:  tol_q <= cfg_data[TOL_W-1:0];
				REG_MAX_SWEEPS: msw_q <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// host addressing
	assign h_ok   = (32'(row) < GRID_MAX) && (32'(col) < GRID_MAX);
	assign h_addr = AW'(32'(row) * GRID_MAX + 32'(col));

	always_comb begin
		if (cmd.host_rd)
			addr_a = h_addr;
		else if (cmd.rd_vert)
			addr_a = ca_q - G_A;
		else if (cmd.rd_horz)
			addr_a = ca_q - AW'(1);
		else
			addr_a = ca_q;
	end
	assign addr_b = cmd.rd_vert ? (ca_q + G_A) : (ca_q + AW'(1));

	// host writes land in both banks; the end-of-run copy keeps the interior level
	assign waddr = cmd.host_wr ? h_addr : ca_q;
	assign wdata = cmd.host_wr ? value : (cmd.cpy ? da : new_val);
	assign we0   = (cmd.host_wr && h_ok) || ((cmd.upd || cmd.cpy) && cur_q);
	assign we1   = (cmd.host_wr && h_ok) || ((cmd.upd || cmd.cpy) && !cur_q);

	always_ff @(posedge clk) begin
		if (we0)
			mem0[waddr] <= wdata;
		if (we1)
			mem1[waddr] <= wdata;
		ra0_q <= mem0[addr_a];
		rb0_q <= mem0[addr_b];
		ra1_q <= mem1[addr_a];
		rb1_q <= mem1[addr_b];
	end

	assign da = cur_q ? ra1_q : ra0_q;
	assign db = cur_q ? rb1_q : rb0_q;

	// stencil arithmetic; floor of sum/4 is the arithmetic shift
	assign new_val = sum_q[SW-1:2];
	assign dsub    = PW'(da) - PW'(new_val);
	assign dabs    = dsub[PW-1] ? -dsub : dsub;

	always_ff @(posedge clk) begin
		if (cmd.add_vert)
			psum_q <= PW'(da) + PW'(db);
		if (cmd.add_horz)
			sum_q <= SW'(psum_q) + SW'(da) + SW'(db);
		if (cmd.upd)
			diff_q <= dabs[DW-1:0];
	end

	// grid side clamped to 3..GRID_MAX, held as last interior index
	always_comb begin
		if (gs_q < GS_W'(3))
			lim_c = RW'(1);
		else if (32'(gs_q) > GRID_MAX)
			lim_c = RW'(GRID_MAX - 2);
		else
			lim_c = RW'(gs_q - GS_W'(2));
	end

	assign lim_sw = (msw_q == '0) ? MS_W'(1) : msw_q;
	assign conv_c = 64'(max_q) <= 64'(tol_q);
	assign hit_c  = ({1'b0, cnt_q} + 1'b1) >= {1'b0, lim_sw};

	assign stat.last_cell = (i_q == lim_q) && (j_q == lim_q);
	assign stat.stop      = conv_c || hit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= 1'b0;
			rd_ok_q <= 1'b0;
			lim_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			ca_q    <= '0;
			cnt_q   <= '0;
			max_q   <= '0;
			dv_q    <= 1'b0;
			conv_q  <= 1'b0;
		end else begin
			dv_q <= cmd.upd;
			if (cmd.host_rd)
				rd_ok_q <= h_ok;
			if (cmd.start) begin
				lim_q <= lim_c;
				i_q   <= RW'(1);
				j_q   <= RW'(1);
				ca_q  <= ORIGIN;
				cnt_q <= '0;
				max_q <= '0;
			end else if (cmd.sweep_end) begin
				cnt_q  <= cnt_q + 1'b1;
				cur_q  <= !cur_q;
				conv_q <= conv_c;
				max_q  <= '0;
				i_q    <= RW'(1);
				j_q    <= RW'(1);
				ca_q   <= ORIGIN;
			end else begin
				if (dv_q && (diff_q > max_q))
					max_q <= diff_q;
				if (cmd.step) begin
					if (j_q == lim_q) begin
						j_q  <= RW'(1);
						i_q  <= i_q + 1'b1;
						ca_q <= ca_q + G_A - AW'(lim_q) + AW'(1);
					end else begin
						j_q  <= j_q + 1'b1;
						ca_q <= ca_q + AW'(1);
					end
				end
			end
		end
	end

	assign host_value    = rd_ok_q ? da : '0;
	assign sweep_total   = cnt_q;
	assign run_converged = conv_q;

endmodule

>>> src/jgr_ctrl.sv
`timescale 1ns / 1ps
// Controller: input acceptance, per-cell read/accumulate/update sequence,
// sweep loop and result hand-off. Depends on jgr_pkg.
module jgr_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [jgr_pkg::MODE_W-1:0]    mode,
	output logic                          in_stall,
	input  logic [1:0]                    q_cnt,
	input  logic                          q_pop,
	input  jgr_pkg::jgr_stat_t            stat,
	output jgr_pkg::jgr_cmd_t             cmd,
	output jgr_pkg::jgr_push_t            push
);
	import jgr_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_RD0   = 10'b00_0000_0010,
		S_RD1   = 10'b00_0000_0100,
		S_RD2   = 10'b00_0000_1000,
		S_UPD   = 10'b00_0001_0000,
		S_FLUSH = 10'b00_0010_0000,
		S_CHK   = 10'b00_0100_0000,
		S_CP0   = 10'b00_1000_0000,
		S_CP1   = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_rd_q;
	logic   accept, room, out_room;
	logic [2:0] occ;

	// slots taken once the pending host result lands and any pop completes
	assign occ      = 3'(q_cnt) + 3'(pend_q) - 3'(q_pop);
	assign room     = occ < 3'd2;
	assign out_room = (q_cnt < 2'd2) || q_pop;
	assign in_stall = (state_q != S_IDLE) || !room;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		if (accept) begin
			case (mode)
				MODE_WRITE: cmd.host_wr = 1'b1;
				MODE_RUN:   cmd.start   = 1'b1;
				MODE_READ:  cmd.host_rd = 1'b1;
				default: ;
			endcase
		end
		case (state_q)
			S_RD0: cmd.rd_vert = 1'b1;
			S_RD1: begin
				cmd.rd_horz  = 1'b1;
				cmd.add_vert = 1'b1;
			end
			S_RD2: begin
				cmd.rd_mid   = 1'b1;
				cmd.add_horz = 1'b1;
			end
			S_UPD: begin
				cmd.upd  = 1'b1;
				cmd.step = 1'b1;
			end
			S_CHK:   cmd.sweep_end = 1'b1;
			S_CP0:   cmd.rd_mid = 1'b1;
			S_CP1: begin
				cmd.cpy  = 1'b1;
				cmd.step = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (cmd.start) state_d = S_RD0;
			S_RD0:   state_d = S_RD1;
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_UPD;
			S_UPD:   state_d = stat.last_cell ? S_FLUSH : S_RD0;
			S_FLUSH: state_d = S_CHK;
			S_CHK:   state_d = stat.stop ? S_CP0 : S_RD0;
			S_CP0:   state_d = S_CP1;
			S_CP1:   state_d = stat.last_cell ? S_OUT : S_CP0;
			S_OUT:   if (out_room) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pend_q    <= 1'b0;
			pend_rd_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pend_q    <= accept && (mode != MODE_RUN);
			pend_rd_q <= cmd.host_rd;
		end
	end

	assign push.host = pend_q;
	assign push.rd   = pend_rd_q;
	assign push.run  = (state_q == S_OUT) && out_room;

endmodule

>>> src/jgr_outq.sv
`timescale 1ns / 1ps
// Two-entry result queue between the core and the output channel.
// Depends on jgr_pkg.
module jgr_outq #(
	parameter int VALUE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic signed [VALUE_BITS-1:0]  push_rv,
	input  logic [jgr_pkg::SC_W-1:0]      push_sc,
	input  logic                          push_cv,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_BITS-1:0]  read_value,
	output logic [jgr_pkg::SC_W-1:0]      sweep_count,
	output logic                          converged,
	output logic [1:0]                    cnt,
	output logic                          pop
);
	import jgr_pkg::*;

	logic signed [VALUE_BITS-1:0] rv_q [2];
	logic [SC_W-1:0]              sc_q [2];
	logic                         cv_q [2];
	logic                         wp_q, rp_q;
	logic [1:0]                   cnt_q;

	assign out_valid = cnt_q != 2'd0;
	assign pop       = out_valid && !out_stall;
	assign cnt       = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			rv_q[wp_q] <= push_rv;
			sc_q[wp_q] <= push_sc;
			cv_q[wp_q] <= push_cv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign read_value  = rv_q[rp_q];
	assign sweep_count = sc_q[rp_q];
	assign converged   = cv_q[rp_q];

endmodule
